/* sv/kcl_pkg.sv */
// kcl_pkg: types, codes and constants shared by the keypad code lock modules.
// No dependencies.
package kcl_pkg;

   localparam int CODE_DIGITS = 4;
   localparam int IDX_W       = (CODE_DIGITS > 1) ? $clog2(CODE_DIGITS) : 1;
   localparam int TICK_W      = 10;

   localparam logic [TICK_W-1:0] TIMEOUT_RESET = TICK_W'(60);
   localparam logic [TICK_W-1:0] TICK_MAX      = '1;
   localparam logic [IDX_W-1:0]  LAST_IDX      = IDX_W'(CODE_DIGITS - 1);

   localparam logic [3:0] KEY_DIGIT_MAX = 4'd9;
   localparam logic [3:0] KEY_STAR      = 4'd10;
   localparam logic [3:0] KEY_HASH      = 4'd11;

   localparam logic FUNC_KEY  = 1'b0;
   localparam logic FUNC_TICK = 1'b1;

   typedef enum logic [2:0] {
      EV_NONE         = 3'd0,
      EV_CORRECT      = 3'd1,
      EV_WRONG        = 3'd2,
      EV_CHANGED      = 3'd3,
      EV_INTERRUPTED  = 3'd4,
      EV_TIMEOUT      = 3'd5,
      EV_MODE_CHANGED = 3'd6,
      EV_RESTART      = 3'd7
   } event_type;

   typedef enum logic [1:0] {
      MODE_NORMAL  = 2'd0,
      MODE_VERIFY  = 2'd1,
      MODE_NEWCODE = 2'd2
   } mode_type;

   typedef logic [3:0] digit_type;
   typedef digit_type [CODE_DIGITS-1:0] code_type;

   typedef struct packed {
      logic       func;
      logic [3:0] key_code;
   } req_type;

   typedef struct packed {
      logic [2:0] event_res;
      logic [1:0] mode;
   } rsp_type;

   function automatic code_type default_code();
      code_type c;
      for (int i = 0; i < CODE_DIGITS; i++) begin
         c[i] = digit_type'((i + 1) % 10);
      end
      return c;
   endfunction

endpackage

/* sv/kcl_in_stage.sv */
// kcl_in_stage: input register holding one key or tick transfer.
// Depends on kcl_pkg.
module kcl_in_stage (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  kcl_pkg::req_type req_data,
   output logic             stg_valid,
   input  logic             stg_ready,
   output kcl_pkg::req_type stg_data
);
   import kcl_pkg::*;

   logic    valid_ff, valid_in;
   req_type data_ff, data_in;

   assign req_ready = !valid_ff || stg_ready;
   assign stg_valid = valid_ff;
   assign stg_data  = data_ff;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (req_ready) begin
         valid_in = req_valid;
         if (req_valid) begin
            data_in = req_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

endmodule

/* sv/kcl_core.sv */
// kcl_core: lock state, single-pass step logic and result register.
// Depends on kcl_pkg.
module kcl_core (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      stg_valid,
   output logic                      stg_ready,
   input  kcl_pkg::req_type          stg_data,
   input  logic [kcl_pkg::TICK_W-1:0] timeout_ticks,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output kcl_pkg::rsp_type          rsp_data
);
   import kcl_pkg::*;

   mode_type          mode_ff, mode_in;
   logic [IDX_W-1:0]  count_ff, count_in;
   code_type          entry_ff, entry_in;
   code_type          stored_ff, stored_in;
   logic [TICK_W-1:0] elapsed_ff, elapsed_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic              fire;
   mode_type          cur_mode;
   event_type         ev;
   code_type          full_entry;
   logic              match;
   logic [TICK_W-1:0] elapsed_inc;

   assign stg_ready = !rsp_valid_ff || rsp_ready;
   assign fire      = stg_valid && stg_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      full_entry = entry_ff;
      full_entry[LAST_IDX] = stg_data.key_code;
      match = (full_entry == stored_ff);
   end

   assign elapsed_inc = (elapsed_ff == TICK_MAX) ? elapsed_ff : elapsed_ff + TICK_W'(1);

   always_comb begin
      case (mode_ff)
         MODE_VERIFY:  cur_mode = MODE_VERIFY;
         MODE_NEWCODE: cur_mode = MODE_NEWCODE;
         default:      cur_mode = MODE_NORMAL;
      endcase

      mode_in    = cur_mode;
      count_in   = count_ff;
      entry_in   = entry_ff;
      stored_in  = stored_ff;
      elapsed_in = elapsed_ff;
      ev         = EV_NONE;

      if (stg_data.func == FUNC_TICK) begin
         if (count_ff == '0) begin
            elapsed_in = '0;
         end else begin
            elapsed_in = elapsed_inc;
            if (elapsed_inc >= timeout_ticks) begin
               count_in   = '0;
               elapsed_in = '0;
               mode_in    = MODE_NORMAL;
               ev         = EV_TIMEOUT;
            end
         end
      end else if (stg_data.key_code <= KEY_DIGIT_MAX) begin
         entry_in[count_ff] = stg_data.key_code;
         if (count_ff != LAST_IDX) begin
            count_in = count_ff + IDX_W'(1);
         end else begin
            count_in   = '0;
            elapsed_in = '0;
            if (cur_mode == MODE_NEWCODE) begin
               stored_in = full_entry;
               mode_in   = MODE_NORMAL;
               ev        = EV_CHANGED;
            end else if (match) begin
               ev = EV_CORRECT;
               if (cur_mode == MODE_VERIFY) begin
                  mode_in = MODE_NEWCODE;
               end
            end else begin
               ev = EV_WRONG;
            end
         end
      end else if (stg_data.key_code == KEY_STAR || stg_data.key_code == KEY_HASH) begin
         count_in   = '0;
         elapsed_in = '0;
         case (cur_mode)
            MODE_NORMAL: begin
               if (stg_data.key_code == KEY_HASH) begin
                  ev = EV_INTERRUPTED;
               end else begin
                  ev      = EV_MODE_CHANGED;
                  mode_in = MODE_VERIFY;
               end
            end
            MODE_VERIFY: begin
               if (stg_data.key_code == KEY_HASH) begin
                  mode_in = MODE_NORMAL;
               end else begin
                  ev = EV_RESTART;
               end
            end
            default: begin
               mode_in = MODE_NORMAL;
            end
         endcase
      end

      rsp_data_in.event_res = ev;
      rsp_data_in.mode      = mode_in;

      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_NORMAL;
         count_ff     <= '0;
         stored_ff    <= default_code();
         elapsed_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            mode_ff    <= mode_in;
            count_ff   <= count_in;
            stored_ff  <= stored_in;
            elapsed_ff <= elapsed_in;
         end
      end
      if (fire) begin
         entry_ff    <= entry_in;
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

/* sv/keypad_code_lock.sv */
// keypad_code_lock: top level of the four-digit keypad code lock.
// Depends on kcl_pkg, kcl_in_stage and kcl_core.
//
//   channel  ports                         payload
//   req      req_valid/req_ready/req_data  req_type: func, key_code
//   rsp      rsp_valid/rsp_ready/rsp_data  rsp_type: event_res, mode
//   csr      csr_valid/csr_ready/csr_data  timeout_ticks, 10 bits
//
// One result per input transfer, one transfer per cycle sustained while rsp_ready stays high.
// Path: input register, then step logic into the result register.
// A stalled rsp backs up into the input register before req_ready drops.
// Synchronous reset restores code 1,2,3,4, normal mode and timeout 60; no clearing pass.
module keypad_code_lock (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  kcl_pkg::req_type           req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output kcl_pkg::rsp_type           rsp_data,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [kcl_pkg::TICK_W-1:0] csr_data
);
   import kcl_pkg::*;

   logic              stg_valid, stg_ready;
   req_type           stg_data;
   logic [TICK_W-1:0] timeout_ff, timeout_in;

   assign csr_ready  = 1'b1;
   assign timeout_in = (csr_valid && csr_ready) ? csr_data : timeout_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
      end else begin
         timeout_ff <= timeout_in;
      end
   end

   kcl_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .stg_valid (stg_valid),
      .stg_ready (stg_ready),
      .stg_data  (stg_data)
   );

   kcl_core u_core (
      .clock         (clock),
      .reset         (reset),
      .stg_valid     (stg_valid),
      .stg_ready     (stg_ready),
      .stg_data      (stg_data),
      .timeout_ticks (timeout_ff),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data)
   );

endmodule
